// ----- rtl/dbd_pkg.sv -----
package dbd_pkg;

  // Field widths fixed by the interface.
  localparam int DAY_BITS          = 5;
  localparam int MONTH_BITS        = 4;
  localparam int FIELD_YEAR_BITS   = 16;
  localparam int COUNT_BITS        = 26;
  localparam int ORDER_BITS        = 2;
  localparam int MONTH_OFFSET_BITS = 9;

  // Default number of significant year bits.
  localparam int DEFAULT_YEAR_BITS = 16;

  // Calendar constants.
  localparam int DAYS_PER_YEAR    = 365;
  localparam int CENTURY_QUARTERS = 25;  // a century holds 25 four-year groups

  // Division by 25 as a multiply by a reciprocal and a right shift.
  // Exact for dividends below 2^15, which covers a quarter year of 16 bits.
  localparam int DIV25_SHIFT      = 19;
  localparam int DIV25_RECIP_BITS = 15;
  localparam logic [DIV25_RECIP_BITS-1:0] DIV25_RECIP = 15'd20972;

  // Order codes.
  localparam logic [ORDER_BITS-1:0] ORDER_EARLIER = 2'd0;
  localparam logic [ORDER_BITS-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_BITS-1:0] ORDER_LATER   = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [DAY_BITS-1:0]        first_day;
    logic [MONTH_BITS-1:0]      first_month;
    logic [FIELD_YEAR_BITS-1:0] first_year;
    logic [DAY_BITS-1:0]        second_day;
    logic [MONTH_BITS-1:0]      second_month;
    logic [FIELD_YEAR_BITS-1:0] second_year;
  } dates_t;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] day_count;
    logic [ORDER_BITS-1:0]        order;
  } result_t;

  // One date with its year already reduced to the significant bits.
  typedef struct packed {
    logic [DAY_BITS-1:0]        day;
    logic [MONTH_BITS-1:0]      month;
    logic [FIELD_YEAR_BITS-1:0] year;
  } date_t;

  // Work handed from the front to the back.
  typedef struct packed {
    date_t                 first;
    date_t                 second;
    logic [ORDER_BITS-1:0] order;
  } job_t;

  // Days in the months before the given one in a common year. Months past
  // twelve count the whole year, and month zero counts nothing.
  function automatic logic [MONTH_OFFSET_BITS-1:0] month_offset(
    input logic [MONTH_BITS-1:0] month
  );
    logic [MONTH_OFFSET_BITS-1:0] days;
    unique case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      4'd12:      days = 9'd334;
      default:    days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

// ----- rtl/days_between_dates_core.sv -----
// Channel   Ports                 Handshake
// input     dates (dates_t)       taken at a clock edge with start high and busy low
// result    result (result_t)     valid for the one cycle that done is high
//
// One item is taken per cycle.
// The front register loads at the accepting edge; done then follows one pass through the
// queue, the three stages of each ordinal unit and the output register.
// Reset (rst, synchronous) empties the front stage, the queue and the back pipeline.
// The receiver cannot stall; busy rises only if the queue is full, which the
// back, draining one item every cycle, never lets happen.
module days_between_dates_core #(
  parameter int YEAR_BITS = dbd_pkg::DEFAULT_YEAR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dbd_pkg::dates_t  dates,
  output logic             busy,
  output logic             done,
  output dbd_pkg::result_t result
);

  logic          queue_full;
  logic          push;
  dbd_pkg::job_t push_job;
  logic          pop;
  logic          empty;
  dbd_pkg::job_t pop_job;

  dbd_front #(.YEAR_BITS(YEAR_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .dates      (dates),
    .busy       (busy),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  dbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (empty),
    .pop_job  (pop_job)
  );

  dbd_back #(.YEAR_BITS(YEAR_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- rtl/dbd_front.sv -----
module dbd_front #(
  parameter int YEAR_BITS = dbd_pkg::DEFAULT_YEAR_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dbd_pkg::dates_t dates,
  output logic            busy,
  input  logic            queue_full,
  output logic            push,
  output dbd_pkg::job_t   push_job
);

  localparam int YW = (YEAR_BITS < dbd_pkg::FIELD_YEAR_BITS) ?
                      YEAR_BITS : dbd_pkg::FIELD_YEAR_BITS;

  logic                  valid;
  dbd_pkg::job_t         job;
  logic                  stall;
  logic                  accept;
  dbd_pkg::job_t         job_next;
  logic [YW-1:0]         year1;
  logic [YW-1:0]         year2;

  // The front stage holds its item while the queue has no room.
  assign stall  = valid && queue_full;
  assign busy   = stall;
  assign accept = start && !busy;

  // Reduce the years and classify the order of the two dates.
  always_comb begin
    year1 = dates.first_year[YW-1:0];
    year2 = dates.second_year[YW-1:0];
    job_next.first.day     = dates.first_day;
    job_next.first.month   = dates.first_month;
    job_next.first.year    = dbd_pkg::FIELD_YEAR_BITS'(year1);
    job_next.second.day    = dates.second_day;
    job_next.second.month  = dates.second_month;
    job_next.second.year   = dbd_pkg::FIELD_YEAR_BITS'(year2);
    if (year1 != year2) begin
      job_next.order = (year1 > year2) ? dbd_pkg::ORDER_LATER : dbd_pkg::ORDER_EARLIER;
    end else if (dates.first_month != dates.second_month) begin
      job_next.order = (dates.first_month > dates.second_month) ?
                       dbd_pkg::ORDER_LATER : dbd_pkg::ORDER_EARLIER;
    end else if (dates.first_day != dates.second_day) begin
      job_next.order = (dates.first_day > dates.second_day) ?
                       dbd_pkg::ORDER_LATER : dbd_pkg::ORDER_EARLIER;
    end else begin
      job_next.order = dbd_pkg::ORDER_EQUAL;
    end
  end

  // Front register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!stall) begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      job <= job_next;
    end
  end

  assign push     = valid && !queue_full;
  assign push_job = job;

endmodule

// ----- rtl/dbd_queue.sv -----
module dbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dbd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dbd_pkg::job_t pop_job
);

  localparam int PW = (dbd_pkg::QUEUE_DEPTH > 1) ? $clog2(dbd_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(dbd_pkg::QUEUE_DEPTH + 1);

  dbd_pkg::job_t entries [dbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(dbd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(dbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(dbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/dbd_ordinal.sv -----
module dbd_ordinal #(
  parameter int YEAR_BITS = dbd_pkg::DEFAULT_YEAR_BITS
) (
  input  logic                           clk,
  input  dbd_pkg::date_t                 date,
  output logic [dbd_pkg::COUNT_BITS-1:0] ordinal
);

  localparam int YW  = (YEAR_BITS < dbd_pkg::FIELD_YEAR_BITS) ?
                       YEAR_BITS : dbd_pkg::FIELD_YEAR_BITS;
  localparam int QW  = YW - 2;
  localparam int PW  = QW + dbd_pkg::DIV25_RECIP_BITS;
  localparam int RW  = PW - dbd_pkg::DIV25_SHIFT;
  localparam int MW  = YW + dbd_pkg::MONTH_OFFSET_BITS;
  localparam int CB  = dbd_pkg::COUNT_BITS;
  localparam int LW  = dbd_pkg::MONTH_OFFSET_BITS + 1;

  logic [YW-1:0] year;
  logic [YW-1:0] prev_year;

  // Stage one registers: products and the pieces they need later.
  logic [CB-1:0] s1_year_days;
  logic [PW-1:0] s1_prod_y;
  logic [PW-1:0] s1_prod_p;
  logic [QW-1:0] s1_quarter_y;
  logic [QW-1:0] s1_quarter_p;
  logic          s1_year_nz;
  logic          s1_div4;
  logic [dbd_pkg::MONTH_OFFSET_BITS-1:0] s1_month_days;
  logic          s1_past_feb;
  logic [dbd_pkg::DAY_BITS-1:0] s1_day;

  // Stage two logic and registers.
  logic [RW-1:0] cent_y;
  logic [RW-1:0] cent_p;
  logic [QW-1:0] cent_rem;
  logic          leap;
  logic [CB-1:0] s2_year_part;
  logic [LW-1:0] s2_in_year;

  assign year      = date.year[YW-1:0];
  assign prev_year = (year == '0) ? '0 : year - 1'b1;

  // Stage one: days of whole years and the reciprocal products for /25.
  always_ff @(posedge clk) begin
    s1_year_days  <= CB'(MW'(year) * MW'(dbd_pkg::DAYS_PER_YEAR));
    s1_prod_y     <= PW'(year[YW-1:2]) * PW'(dbd_pkg::DIV25_RECIP);
    s1_prod_p     <= PW'(prev_year[YW-1:2]) * PW'(dbd_pkg::DIV25_RECIP);
    s1_quarter_y  <= year[YW-1:2];
    s1_quarter_p  <= prev_year[YW-1:2];
    s1_year_nz    <= (year != '0);
    s1_div4       <= (year[1:0] == 2'b00);
    s1_month_days <= dbd_pkg::month_offset(date.month);
    s1_past_feb   <= (date.month >= dbd_pkg::MONTH_BITS'(3));
    s1_day        <= date.day;
  end

  // Centuries for this year and the year before, and the leap test.
  always_comb begin
    cent_y   = s1_prod_y[PW-1:dbd_pkg::DIV25_SHIFT];
    cent_p   = s1_prod_p[PW-1:dbd_pkg::DIV25_SHIFT];
    cent_rem = s1_quarter_y - QW'(QW'(cent_y) * QW'(dbd_pkg::CENTURY_QUARTERS));
    leap     = s1_div4 && ((cent_rem != '0) || (cent_y[1:0] == 2'b00));
  end

  // Stage two: year part (year 0 counts as a leap year) and in-year part.
  always_ff @(posedge clk) begin
    s2_year_part <= s1_year_days + CB'(s1_quarter_p) - CB'(cent_p)
                    + CB'(cent_p >> 2) + CB'(s1_year_nz);
    s2_in_year   <= LW'(s1_month_days) + LW'(leap && s1_past_feb) + LW'(s1_day);
  end

  // Stage three: ordinal day number.
  always_ff @(posedge clk) begin
    ordinal <= s2_year_part + CB'(s2_in_year);
  end

endmodule

// ----- rtl/dbd_back.sv -----
module dbd_back #(
  parameter int YEAR_BITS = dbd_pkg::DEFAULT_YEAR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  dbd_pkg::job_t    pop_job,
  output logic             pop,
  output logic             done,
  output dbd_pkg::result_t result
);

  localparam int LAT = 3;

  logic [LAT-1:0]                valid_pipe;
  logic [dbd_pkg::ORDER_BITS-1:0] order_pipe [LAT];
  logic [dbd_pkg::COUNT_BITS-1:0] ordinal1;
  logic [dbd_pkg::COUNT_BITS-1:0] ordinal2;

  // The back never stalls, so it takes an item whenever one waits.
  assign pop = !empty;

  dbd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_first (
    .clk     (clk),
    .date    (pop_job.first),
    .ordinal (ordinal1)
  );

  dbd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_second (
    .clk     (clk),
    .date    (pop_job.second),
    .ordinal (ordinal2)
  );

  // Item valid bits alongside the ordinal pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
      done       <= 1'b0;
    end else begin
      valid_pipe <= {valid_pipe[LAT-2:0], pop};
      done       <= valid_pipe[LAT-1];
    end
  end

  // Order code follows its item.
  always_ff @(posedge clk) begin
    order_pipe[0] <= pop_job.order;
    for (int i = 1; i < LAT; i++) begin
      order_pipe[i] <= order_pipe[i-1];
    end
  end

  // Output register: signed difference of the ordinals.
  always_ff @(posedge clk) begin
    result.day_count <= signed'(ordinal2 - ordinal1);
    result.order     <= order_pipe[LAT-1];
  end

endmodule

// ----- verif/days_between_dates_checker.sv -----
module days_between_dates_checker #(
  parameter int YEAR_BITS = dbd_pkg::DEFAULT_YEAR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  dbd_pkg::dates_t  dates,
  input  logic             done,
  input  dbd_pkg::result_t result,
  output int               mismatches,
  output int               outstanding,
  output int               checked,
  output int               earlier_seen,
  output int               equal_seen,
  output int               later_seen,
  output int               odd_seen
);
  import dbd_pkg::*;

  localparam logic [63:0] YEAR_MASK = (64'd1 << YEAR_BITS) - 64'd1;

  // Spans predicted for accepted date pairs, oldest first.
  result_t span_queue [$];

  int errors = 0;
  int n_checked = 0;
  int n_earlier = 0;
  int n_equal = 0;
  int n_later = 0;
  int n_odd = 0;

  function automatic bit leap_year(logic [63:0] y);
    return ((y % 64'd4 == 64'd0) && (y % 64'd100 != 64'd0)) || (y % 64'd400 == 64'd0);
  endfunction

  function automatic int unsigned month_length(int unsigned k, bit leap_yr);
    case (k)
      2: return leap_yr ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Days since the start of year zero, counting day-of-month as a plain offset.
  function automatic logic [63:0] day_number(
    logic [DAY_BITS-1:0]        d,
    logic [MONTH_BITS-1:0]      m,
    logic [FIELD_YEAR_BITS-1:0] year
  );
    logic [63:0] y;
    logic [63:0] total;
    logic [63:0] prior;
    int unsigned last;
    bit leap_yr;
    y = 64'(year);
    y = y & YEAR_MASK;
    leap_yr = leap_year(y);
    total = y * 64'(DAYS_PER_YEAR);
    // Year zero is itself a leap year, so it adds one extra day for all later years.
    if (y != 64'd0) begin
      prior = y - 64'd1;
      total = total + prior / 64'd4 - prior / 64'd100 + prior / 64'd400 + 64'd1;
    end
    // Months beyond December count the whole year.
    last = (m > 4'd13) ? 32'd13 : 32'(m);
    for (int k = 1; k < last; k++) begin
      total = total + 64'(month_length(k, leap_yr));
    end
    return total + 64'(d);
  endfunction

  function automatic result_t predict_span(dates_t p);
    result_t r;
    logic [63:0] y1;
    logic [63:0] y2;
    logic [63:0] span;
    y1 = 64'(p.first_year);
    y1 = y1 & YEAR_MASK;
    y2 = 64'(p.second_year);
    y2 = y2 & YEAR_MASK;
    span = day_number(p.second_day, p.second_month, p.second_year) -
           day_number(p.first_day, p.first_month, p.first_year);
    r.day_count = span[COUNT_BITS-1:0];
    // The order is a plain comparison of year, then month, then day.
    if (y1 != y2) begin
      r.order = (y1 > y2) ? ORDER_LATER : ORDER_EARLIER;
    end else if (p.first_month != p.second_month) begin
      r.order = (p.first_month > p.second_month) ? ORDER_LATER : ORDER_EARLIER;
    end else if (p.first_day != p.second_day) begin
      r.order = (p.first_day > p.second_day) ? ORDER_LATER : ORDER_EARLIER;
    end else begin
      r.order = ORDER_EQUAL;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Compare each result with the oldest prediction, then record newly accepted items.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (span_queue.size() == 0) begin
        note_failure($sformatf("result count %0d order %0d arrived with nothing pending",
                               result.day_count, result.order));
      end else begin
        want = span_queue.pop_front();
        n_checked++;
        if (want.order == ORDER_EARLIER) begin
          n_earlier++;
        end else if (want.order == ORDER_EQUAL) begin
          n_equal++;
        end else begin
          n_later++;
        end
        if (result.day_count !== want.day_count || result.order !== want.order) begin
          note_failure($sformatf("mismatch: expected count %0d order %0d, got count %0d order %0d",
                                 want.day_count, want.order, result.day_count, result.order));
        end
      end
    end
    if (!rst && start && !busy) begin
      span_queue.push_back(predict_span(dates));
      if (dates.first_day == 0 || dates.second_day == 0 ||
          dates.first_month == 0 || dates.second_month == 0 ||
          dates.first_month > 12 || dates.second_month > 12) begin
        n_odd++;
      end
    end
    mismatches   <= errors;
    outstanding  <= span_queue.size();
    checked      <= n_checked;
    earlier_seen <= n_earlier;
    equal_seen   <= n_equal;
    later_seen   <= n_later;
    odd_seen     <= n_odd;
  end

endmodule

// ----- verif/tb_days_between_dates_core.sv -----
module tb_days_between_dates_core;
  import dbd_pkg::*;

  localparam int YEAR_BITS    = DEFAULT_YEAR_BITS;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_TAIL    = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  dates_t  dates = '0;
  logic    busy;
  logic    done;
  result_t result;

  int mismatches;
  int outstanding;
  int checked;
  int earlier_seen;
  int equal_seen;
  int later_seen;
  int odd_seen;

  always #5 clk = ~clk;

  days_between_dates_core #(.YEAR_BITS(YEAR_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .dates  (dates),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  days_between_dates_checker #(.YEAR_BITS(YEAR_BITS)) span_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .dates        (dates),
    .done         (done),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked),
    .earlier_seen (earlier_seen),
    .equal_seen   (equal_seen),
    .later_seen   (later_seen),
    .odd_seen     (odd_seen)
  );

  function automatic dates_t pair(
    int d1, int m1, int y1,
    int d2, int m2, int y2
  );
    dates_t p;
    p.first_day    = DAY_BITS'(d1);
    p.first_month  = MONTH_BITS'(m1);
    p.first_year   = FIELD_YEAR_BITS'(y1);
    p.second_day   = DAY_BITS'(d2);
    p.second_month = MONTH_BITS'(m2);
    p.second_year  = FIELD_YEAR_BITS'(y2);
    return p;
  endfunction

  // Years spread over the full field, around century boundaries and near the ends.
  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 655) * 100 + $urandom_range(0, 4));
      2: return 16'($urandom_range(1583, 2400));
      default: return $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) :
                                             16'($urandom_range(65527, 65535));
    endcase
  endfunction

  function automatic date_t valid_date(input logic [15:0] year);
    date_t dt;
    int unsigned len;
    bit leap_yr;
    leap_yr = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    dt.year = year;
    dt.month = MONTH_BITS'($urandom_range(1, 12));
    case (dt.month)
      4'd2: len = leap_yr ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      default: len = 31;
    endcase
    dt.day = DAY_BITS'($urandom_range(1, len));
    return dt;
  endfunction

  // Mostly well-formed date pairs, with a share of raw bit patterns.
  function automatic dates_t random_pair();
    date_t a;
    date_t b;
    logic [63:0] raw;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    a = valid_date(pick_year());
    if (pick < 50) begin
      b = valid_date(pick_year());
    end else if (pick < 70) begin
      b = valid_date(16'(a.year + $urandom_range(0, 6) - 3));
    end else if (pick < 80) begin
      b = a;
      b.day = DAY_BITS'($urandom_range(1, 28));
    end else if (pick < 85) begin
      b = a;
    end else begin
      return raw[$bits(dates_t)-1:0];
    end
    return {a, b};
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_dates(input dates_t p);
    start <= 1'b1;
    dates <= p;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a while; the payload wanders meanwhile and must be ignored.
  task automatic idle_for(input int unsigned cycles);
    logic [63:0] raw;
    start <= 1'b0;
    repeat (cycles) begin
      raw = {$urandom, $urandom};
      dates <= raw[$bits(dates_t)-1:0];
      @(posedge clk);
    end
  endtask

  initial begin
    dates_t directed [$];
    bit idle_on;
    idle_on = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, leap-year rules, every order and the out-of-range dates.
    directed.push_back(pair(1, 1, 0, 1, 1, 0));
    directed.push_back(pair(1, 1, 0, 31, 12, 65535));
    directed.push_back(pair(31, 12, 65535, 1, 1, 0));
    directed.push_back(pair(28, 2, 1900, 1, 3, 1900));
    directed.push_back(pair(28, 2, 2000, 1, 3, 2000));
    directed.push_back(pair(29, 2, 2024, 1, 3, 2024));
    directed.push_back(pair(31, 12, 1999, 1, 1, 2000));
    directed.push_back(pair(1, 3, 0, 1, 3, 1));
    directed.push_back(pair(5, 0, 2023, 5, 1, 2023));
    directed.push_back(pair(1, 13, 2023, 1, 1, 2024));
    directed.push_back(pair(31, 15, 65535, 0, 0, 0));
    directed.push_back(pair(0, 3, 2021, 28, 2, 2021));
    directed.push_back(pair(31, 2, 2021, 3, 3, 2021));
    directed.push_back(pair(31, 4, 2020, 1, 5, 2020));
    directed.push_back(pair(1, 2, 2020, 0, 13, 2019));
    directed.push_back(pair(15, 6, 2010, 14, 6, 2010));
    directed.push_back(pair(14, 6, 2010, 15, 6, 2010));
    directed.push_back(pair(31, 15, 65535, 31, 15, 65535));
    directed.push_back(pair(0, 0, 0, 0, 0, 0));
    directed.push_back(pair(1, 1, 65535, 1, 1, 65534));
    directed.push_back(pair(29, 2, 400, 29, 2, 800));
    directed.push_back(pair(1, 1, 1, 1, 1, 0));
    directed.push_back(pair(0, 14, 100, 31, 1, 101));

    foreach (directed[i]) begin
      send_dates(directed[i]);
      if ($urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 12));
      end
    end

    // Let the pipeline empty completely before the random traffic.
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_dates(random_pair());
      if (idle_on && i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        idle_for($urandom_range(1, 12));
      end
    end
    start <= 1'b0;

    // Wait for the last results, then keep watching for anything stray.
    for (int n = 0; n < 1000 && outstanding != 0; n++) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);

    if (outstanding != 0) begin
      $display("%0d expected results never arrived.", outstanding);
    end
    $display("%0d date pairs checked: %0d earlier, %0d equal, %0d later.",
             checked, earlier_seen, equal_seen, later_seen);
    $display("%0d of them had a zero day or a month outside January to December.", odd_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_days_between_dates_core passed");
    end else begin
      $display("tb_days_between_dates_core failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("tb_days_between_dates_core failed");
    $finish;
  end

endmodule
